/* sv/ecee_pkg.sv */
`timescale 1ns / 1ps

package ecee_pkg;

    // escape codes
    localparam logic [7:0] ESC_LEAD = 8'hAA;
    localparam logic [7:0] MARK_A   = 8'h55;
    localparam logic [7:0] MARK_B   = 8'hAA;
    localparam logic [7:0] SUB_A    = 8'h5A;
    localparam logic [7:0] SUB_B    = 8'hA5;

    localparam logic [15:0] GAP_RESET = 16'd1;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // input beat
    typedef struct packed {
        logic [15:0] sample;
        logic [15:0] upper_bound;
        logic [15:0] lower_bound;
    } t_in;

    // output beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
        logic       out_of_envelope;
        logic       ng_latched;
    } t_out;

    // classified sample as queued for the back end
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            sent;
        logic            oor;
        logic            ng;
    } t_entry;

    // escaped form of one byte
    typedef struct packed {
        logic       two;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_esc;

    function automatic t_esc escape_byte(input logic [7:0] b);
        t_esc e;
        e.two = 1'b0;
        e.b0  = b;
        e.b1  = 8'h00;
        if (b == MARK_A) begin
            e.two = 1'b1;
            e.b0  = ESC_LEAD;
            e.b1  = SUB_A;
        end else if (b == MARK_B) begin
            e.two = 1'b1;
            e.b0  = ESC_LEAD;
            e.b1  = SUB_B;
        end
        return e;
    endfunction

endpackage

/* sv/ecee_front.sv */
`timescale 1ns / 1ps

module ecee_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [15:0]           i_cfg_data,
    input  logic                  i_accept,
    input  ecee_pkg::t_in         i_item,
    output ecee_pkg::t_entry      o_entry
);
    import ecee_pkg::*;

    logic [15:0] r_gap;
    logic [15:0] r_count;
    logic        r_ng;
    logic [15:0] n_count;
    logic        n_ng;

    logic        oor;
    logic [15:0] gap;
    logic [16:0] cnt_inc;
    t_esc        esc_hi;
    t_esc        esc_lo;

    // envelope verdict and sticky flag
    assign oor  = (i_item.sample > i_item.upper_bound) ||
                  (i_item.sample < i_item.lower_bound);
    assign n_ng = r_ng | oor;

    // decimation counter, a gap of zero acts as one
    assign gap     = (r_gap == 16'd0) ? 16'd1 : r_gap;
    assign cnt_inc = {1'b0, r_count} + 17'd1;
    assign n_count = (cnt_inc >= {1'b0, gap}) ? 16'd0 : cnt_inc[15:0];

    // escape both bytes, high byte first
    assign esc_hi = escape_byte(i_item.sample[15:8]);
    assign esc_lo = escape_byte(i_item.sample[7:0]);

    always_comb begin
        o_entry.bytes    = '0;
        o_entry.last_idx = 2'd0;
        o_entry.sent     = (r_count == 16'd0);
        o_entry.oor      = oor;
        o_entry.ng       = n_ng;
        if (o_entry.sent) begin
            o_entry.bytes[0] = esc_hi.b0;
            if (esc_hi.two) begin
                o_entry.bytes[1] = esc_hi.b1;
                o_entry.bytes[2] = esc_lo.b0;
                o_entry.bytes[3] = esc_lo.b1;
            end else begin
                o_entry.bytes[1] = esc_lo.b0;
                o_entry.bytes[2] = esc_lo.b1;
            end
            o_entry.last_idx = 2'd1 + {1'b0, esc_hi.two} + {1'b0, esc_lo.two};
        end
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap   <= GAP_RESET;
            r_count <= 16'd0;
            r_ng    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_gap <= i_cfg_data;
            end
            if (i_accept) begin
                r_count <= n_count;
                r_ng    <= n_ng;
            end
        end
    end

endmodule

/* sv/ecee_queue.sv */
`timescale 1ns / 1ps

module ecee_queue #(
    parameter int P_DEPTH = ecee_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ecee_pkg::t_entry      i_data,
    input  logic                  i_pop,
    output ecee_pkg::t_entry      o_head,
    output logic                  o_empty,
    output logic                  o_full
);
    import ecee_pkg::*;

    localparam int PW = $clog2(P_DEPTH);
    localparam int CW = $clog2(P_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(P_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(P_DEPTH);

    t_entry        r_mem [P_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_FULL);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

/* sv/ecee_back.sv */
`timescale 1ns / 1ps

module ecee_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ecee_pkg::t_entry      i_head,
    input  logic                  i_empty,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output ecee_pkg::t_out        o_out_data
);
    import ecee_pkg::*;

    logic [1:0] r_idx;
    logic [1:0] n_idx;
    logic       r_valid;
    t_out       r_data;
    t_out       n_data;
    logic       load;
    logic       at_last;

    // output register takes a new beat when empty or being drained
    assign load    = (!r_valid || i_out_ready) && !i_empty;
    assign at_last = (r_idx == i_head.last_idx);
    assign o_pop   = load && at_last;
    assign n_idx   = at_last ? 2'd0 : r_idx + 2'd1;

    // one result of the head sample
    always_comb begin
        n_data.out_byte        = i_head.bytes[r_idx];
        n_data.byte_valid      = i_head.sent;
        n_data.last            = at_last;
        n_data.out_of_envelope = i_head.oor;
        n_data.ng_latched      = i_head.ng;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= n_idx;
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= n_data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

/* sv/envelope_check_escape_encoder.sv */
`timescale 1ns / 1ps
// the first result of a sample passes through the queue and then the back end's output register
// throughput: one result beat per cycle from the back end's output register while the receiver is ready,
//   so a skipped sample gives one beat and a sent sample 2 to 4 beats (one per escaped byte)
// the input is taken while the queue between front and back has room
// reset (synchronous, active low) clears the sticky flag, the decimation count, the queue
//   and the output valid, and sets the decimation gap to 1

module envelope_check_escape_encoder #(
    parameter int P_QUEUE_DEPTH = ecee_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ecee_pkg::t_in     i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ecee_pkg::t_out    o_out_data
);
    import ecee_pkg::*;

    t_entry entry;
    t_entry head;
    logic   accept;
    logic   q_empty;
    logic   q_full;
    logic   pop;

    assign o_in_ready = !q_full;
    assign accept     = i_in_valid && !q_full;

    // classify and escape
    ecee_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_item     (i_in_data),
        .o_entry    (entry)
    );

    // decoupling queue
    ecee_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // byte emission
    ecee_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

/* tb/sv/envelope_check_escape_encoder_test.sv */
`timescale 1ns / 1ps

module envelope_check_escape_encoder_test;
    import ecee_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SEG_ITEMS      = 34;
    localparam int NUM_SEGS       = 12;

    // decimation gap per random segment, four segments per idling mode
    localparam logic [15:0] GAP_PLAN [NUM_SEGS] = '{
        16'd2, 16'd1, 16'd3, 16'd0,
        16'd5, 16'd4, 16'hFFFF, 16'd1,
        16'd6, 16'd7, 16'd0, 16'd3
    };

    // one row of the directed table; n_typed of zero means the predictor decides
    typedef struct packed {
        logic        cfg_we;
        logic [15:0] cfg_val;
        logic [15:0] smp;
        logic [15:0] up;
        logic [15:0] lo;
        logic [2:0]  n_typed;
        logic [31:0] typ_bytes;
        logic        typ_oor;
        logic        typ_ng;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out_data;

    // envelope and decimation state as the block should hold it
    logic        ng_flag      = 1'b0;
    logic [15:0] sample_count = 16'd0;
    logic [15:0] gap_reg      = GAP_RESET;

    t_out       expected_beats[$];
    t_out       predicted[$];
    logic [7:0] esc_bytes[$];
    t_dir_row   dir_rows[$];

    int mismatches   = 0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int rx_hold_left = 0;
    int idle_cycles  = 0;

    envelope_check_escape_encoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // byte stuffing of one byte into esc_bytes
    function automatic void add_escaped(input logic [7:0] b);
        if (b == MARK_A) begin
            esc_bytes.push_back(ESC_LEAD);
            esc_bytes.push_back(SUB_A);
        end else if (b == MARK_B) begin
            esc_bytes.push_back(ESC_LEAD);
            esc_bytes.push_back(SUB_B);
        end else begin
            esc_bytes.push_back(b);
        end
    endfunction

    // advance the envelope and decimation state by one sample, beats go to predicted
    function automatic void predict_sample(input t_in s);
        logic        oor;
        logic        send;
        logic [15:0] g;
        logic [16:0] nxt;
        t_out        b;
        oor  = (s.sample > s.upper_bound) || (s.sample < s.lower_bound);
        g    = (gap_reg == 16'd0) ? 16'd1 : gap_reg;
        send = (sample_count == 16'd0);
        if (oor)
            ng_flag = 1'b1;
        nxt = {1'b0, sample_count} + 17'd1;
        sample_count = (nxt >= {1'b0, g}) ? 16'd0 : nxt[15:0];
        predicted.delete();
        if (send) begin
            esc_bytes.delete();
            add_escaped(s.sample[15:8]);
            add_escaped(s.sample[7:0]);
            foreach (esc_bytes[k]) begin
                b.out_byte        = esc_bytes[k];
                b.byte_valid      = 1'b1;
                b.last            = (k == esc_bytes.size() - 1);
                b.out_of_envelope = oor;
                b.ng_latched      = ng_flag;
                predicted.push_back(b);
            end
        end else begin
            b.out_byte        = 8'h00;
            b.byte_valid      = 1'b0;
            b.last            = 1'b1;
            b.out_of_envelope = oor;
            b.ng_latched      = ng_flag;
            predicted.push_back(b);
        end
    endfunction

    function automatic t_dir_row mk_row(input int cfg_we, input int cfg_val,
                                        input logic [15:0] smp, input logic [15:0] up,
                                        input logic [15:0] lo, input int n,
                                        input logic [31:0] bytes, input int oor,
                                        input int ng);
        t_dir_row r;
        r = '{1'(cfg_we), 16'(cfg_val), smp, up, lo, 3'(n), bytes, 1'(oor), 1'(ng)};
        return r;
    endfunction

    // random sample, escape codes favored in both bytes, bounds mostly around the sample
    function automatic t_in rand_sample();
        logic [7:0] hi_b;
        logic [7:0] lo_b;
        int         v;
        int         up;
        int         lo;
        int         sel;
        t_in        r;
        hi_b = 8'($urandom);
        lo_b = 8'($urandom);
        if ($urandom_range(9) < 3)
            hi_b = $urandom_range(1) ? MARK_B : MARK_A;
        if ($urandom_range(9) < 3)
            lo_b = $urandom_range(1) ? MARK_B : MARK_A;
        v   = {16'd0, hi_b, lo_b};
        sel = $urandom_range(9);
        if (sel < 6) begin
            lo = v - int'($urandom_range(400));
            up = v + int'($urandom_range(400));
            if (lo < 0)
                lo = 0;
            if (up > 65535)
                up = 65535;
        end else if (sel < 8) begin
            lo = $urandom_range(65535);
            up = $urandom_range(65535);
        end else if (sel == 8) begin
            lo = 0;
            up = (v == 0) ? 0 : v - 1;
        end else begin
            lo = (v == 65535) ? 65535 : v + 1;
            up = 65535;
        end
        r.sample      = v[15:0];
        r.upper_bound = up[15:0];
        r.lower_bound = lo[15:0];
        return r;
    endfunction

    // offer one sample beat, called at a falling edge, returns at a falling edge
    task automatic send_sample(input t_in s, input logic [2:0] n_typed,
                               input logic [31:0] typ_bytes, input logic typ_oor,
                               input logic typ_ng);
        t_out b;
        int   k;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = s;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        predict_sample(s);
        if (n_typed == 3'd0) begin
            foreach (predicted[j])
                expected_beats.push_back(predicted[j]);
        end else begin
            for (k = 0; k < n_typed; k++) begin
                b.out_byte        = typ_bytes[31 - 8 * k -: 8];
                b.byte_valid      = 1'b1;
                b.last            = (k == n_typed - 1);
                b.out_of_envelope = typ_oor;
                b.ng_latched      = typ_ng;
                expected_beats.push_back(b);
            end
        end
        @(negedge i_clk);
    endtask

    // stop offering and wait until every expected beat has come out
    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (expected_beats.size() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_gap(input logic [15:0] v);
        wait_drained();
        i_cfg_we   = 1'b1;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        gap_reg    = v;
    endtask

    // receiver: random stalls, or a long hold-off when asked
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                i_out_ready = 1'b0;
                rx_hold_left--;
            end else begin
                i_out_ready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // compare each result beat with the oldest expected one
    always @(posedge i_clk) begin : check_beat
        t_out want;
        if (o_out_valid && i_out_ready) begin
            if (expected_beats.size() == 0) begin
                $error("result beat with nothing expected: %h", o_out_data);
                mismatches++;
            end else begin
                want = expected_beats.pop_front();
                if (o_out_data.out_byte !== want.out_byte) begin
                    $error("out_byte expected %h got %h", want.out_byte, o_out_data.out_byte);
                    mismatches++;
                end
                if (o_out_data.byte_valid !== want.byte_valid) begin
                    $error("byte_valid expected %b got %b", want.byte_valid,
                           o_out_data.byte_valid);
                    mismatches++;
                end
                if (o_out_data.last !== want.last) begin
                    $error("last expected %b got %b", want.last, o_out_data.last);
                    mismatches++;
                end
                if (o_out_data.out_of_envelope !== want.out_of_envelope) begin
                    $error("out_of_envelope expected %b got %b", want.out_of_envelope,
                           o_out_data.out_of_envelope);
                    mismatches++;
                end
                if (o_out_data.ng_latched !== want.ng_latched) begin
                    $error("ng_latched expected %b got %b", want.ng_latched,
                           o_out_data.ng_latched);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        t_in cur;
        int  mode;
        int  seg;
        int  n;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = 16'd0;
        i_in_valid = 1'b0;
        i_in_data  = '0;

        // reset gap of one: every sample sent, flags easy to read off
        dir_rows.push_back(mk_row(0, 0, 16'h0000, 16'hFFFF, 16'h0000, 2, 32'h0000_0000, 0, 0));
        dir_rows.push_back(mk_row(0, 0, 16'h55AA, 16'hFFFF, 16'h0000, 4, 32'hAA5A_AAA5, 0, 0));
        dir_rows.push_back(mk_row(0, 0, 16'hFFFF, 16'hFFFF, 16'h0000, 2, 32'hFFFF_0000, 0, 0));
        dir_rows.push_back(mk_row(0, 0, 16'hAA55, 16'hFFFF, 16'h0000, 4, 32'hAAA5_AA5A, 0, 0));
        // first sample above the envelope sets the sticky flag
        dir_rows.push_back(mk_row(0, 0, 16'h1234, 16'h1233, 16'h0000, 2, 32'h1234_0000, 1, 1));
        // bounds equal, below lower, crossed bounds, full range
        dir_rows.push_back(mk_row(0, 0, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0, 0, 16'h7FFF, 16'h8000, 16'h8000, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0, 0, 16'h0055, 16'hFFFF, 16'h0056, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0, 0, 16'h5500, 16'h1000, 16'h9000, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0, 0, 16'hAA00, 16'hFFFF, 16'h0000, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0, 0, 16'h00AA, 16'h00AA, 16'h00AA, 0, 0, 0, 0));
        // gap of zero acts as one
        dir_rows.push_back(mk_row(1, 0, 16'h0101, 16'hFFFF, 16'h0000, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0, 0, 16'h00FF, 16'hFFFF, 16'h0000, 0, 0, 0, 0));
        // gap of three, two samples leave the count at two
        dir_rows.push_back(mk_row(1, 3, 16'h3355, 16'hFFFF, 16'h0000, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0, 0, 16'h33AA, 16'hFFFF, 16'h0000, 0, 0, 0, 0));
        // gap lowered below the count: one skip, then the count wraps
        dir_rows.push_back(mk_row(1, 1, 16'h5555, 16'hFFFF, 16'h0000, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0, 0, 16'hAAAA, 16'hFFFF, 16'h0000, 0, 0, 0, 0));
        // largest gap
        dir_rows.push_back(mk_row(1, 'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0, 0, 16'h0000, 16'hFFFF, 16'h0000, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0, 0, 16'h1111, 16'h0000, 16'hFFFF, 0, 0, 0, 0));

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        tx_idle_pct = 37;
        rx_idle_pct = 70;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg_we)
                write_gap(dir_rows[i].cfg_val);
            cur.sample      = dir_rows[i].smp;
            cur.upper_bound = dir_rows[i].up;
            cur.lower_bound = dir_rows[i].lo;
            send_sample(cur, dir_rows[i].n_typed, dir_rows[i].typ_bytes,
                        dir_rows[i].typ_oor, dir_rows[i].typ_ng);
        end

        // random segments under three idling modes
        for (mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    tx_idle_pct = 37;
                    rx_idle_pct = 70;
                end
                1: begin
                    tx_idle_pct = 70;
                    rx_idle_pct = 37;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (seg = 0; seg < 4; seg++) begin
                write_gap(GAP_PLAN[mode * 4 + seg]);
                // long receiver hold-off so the block fills and stalls its input
                if (mode == 0 && seg == 1)
                    rx_hold_left = HOLD_CYCLES;
                for (n = 0; n < SEG_ITEMS; n++) begin
                    if (n == SEG_ITEMS / 2)
                        wait_drained();
                    send_sample(rand_sample(), 3'd0, 32'd0, 1'b0, 1'b0);
                end
            end
        end

        i_in_valid = 1'b0;
        while (expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_beats.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
